[sv/quadratic_nearest_root_defines.svh]
// Assertion macros shared by the quadratic nearest root RTL.
`ifndef QUADRATIC_NEAREST_ROOT_DEFINES_SVH
`define QUADRATIC_NEAREST_ROOT_DEFINES_SVH

// Implication checked on every rising edge outside reset.
`define QNR_ASSERT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Implication checked on every rising edge, reset included.
`define QNR_ASSERT_ALWAYS(label, ante, cons, msg) \
  label: assert property (@(posedge clk) (ante) |-> (cons)) else $error(msg);

`endif

[sv/qnr_pkg.sv]
// Shared types and constants of the quadratic nearest root block.
`default_nettype none
package qnr_pkg;

  localparam int DIST_W     = 32;
  localparam int COEF_W     = 32;
  localparam int EPS_W      = 16;
  localparam int D_W        = 66;
  localparam int ROOT_W     = 33;
  localparam int SREM_W     = 35;
  localparam int NUM_W      = 34;
  localparam int DEN_W      = 33;
  localparam int SQRT_CELLS = 33;

  localparam logic [EPS_W-1:0]  EPS_RESET = 16'd66;
  localparam logic              REG_EPSILON = 1'b0;
  localparam logic [DIST_W-1:0] DIST_MAX = 32'h7FFF_FFFF;
  localparam logic [DIST_W-1:0] DIST_MIN = 32'h8000_0000;

  typedef struct packed {
    logic valid;
    logic go;
    logic neg1;
    logic neg2;
  } ctl_t;

  typedef struct packed {
    logic signed [COEF_W-1:0] a;
    logic signed [COEF_W-1:0] b;
  } ab_t;

endpackage
`default_nettype wire

[sv/qnr_sqrt_cell.sv]
// One cell of the square root chain: settles one root bit per beat.
`default_nettype none
module qnr_sqrt_cell (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        adv,
  input  qnr_pkg::ctl_t               in_ctl,
  input  qnr_pkg::ab_t                in_ab,
  input  logic [qnr_pkg::SREM_W-1:0]  in_rem,
  input  logic [qnr_pkg::ROOT_W-1:0]  in_root,
  input  logic [qnr_pkg::D_W-1:0]     in_d,
  output qnr_pkg::ctl_t               out_ctl,
  output qnr_pkg::ab_t                out_ab,
  output logic [qnr_pkg::SREM_W-1:0]  out_rem,
  output logic [qnr_pkg::ROOT_W-1:0]  out_root,
  output logic [qnr_pkg::D_W-1:0]     out_d
);

  logic [qnr_pkg::SREM_W+1:0] rem_sh;
  logic [qnr_pkg::SREM_W+1:0] trial;
  logic [qnr_pkg::SREM_W+1:0] diff;
  logic                       take;

  // Bring down the next pair of radicand bits and try (root << 2) | 1.
  assign rem_sh = {in_rem, in_d[qnr_pkg::D_W-1 -: 2]};
  assign trial  = (qnr_pkg::SREM_W + 2)'({in_root, 2'b01});
  assign take   = rem_sh >= trial;
  assign diff   = rem_sh - trial;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_ctl <= '0;
    end else if (adv) begin
      out_ctl <= in_ctl;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_ab   <= in_ab;
      out_rem  <= take ? diff[qnr_pkg::SREM_W-1:0] : rem_sh[qnr_pkg::SREM_W-1:0];
      out_root <= {in_root[qnr_pkg::ROOT_W-2:0], take};
      out_d    <= {in_d[qnr_pkg::D_W-3:0], 2'b00};
    end
  end

endmodule
`default_nettype wire

[sv/qnr_div_cell.sv]
// One cell of the divider chain: one quotient bit of both roots per beat.
`default_nettype none
module qnr_div_cell #(
  parameter int NW = 50
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       adv,
  input  qnr_pkg::ctl_t              in_ctl,
  input  logic [qnr_pkg::DEN_W-1:0]  in_den,
  input  logic [qnr_pkg::DEN_W-1:0]  in_rem1,
  input  logic [qnr_pkg::DEN_W-1:0]  in_rem2,
  input  logic [NW-1:0]              in_nq1,
  input  logic [NW-1:0]              in_nq2,
  output qnr_pkg::ctl_t              out_ctl,
  output logic [qnr_pkg::DEN_W-1:0]  out_den,
  output logic [qnr_pkg::DEN_W-1:0]  out_rem1,
  output logic [qnr_pkg::DEN_W-1:0]  out_rem2,
  output logic [NW-1:0]              out_nq1,
  output logic [NW-1:0]              out_nq2
);

  logic [qnr_pkg::DEN_W:0] tmp1, tmp2, dif1, dif2, den_x;
  logic                    ge1, ge2;

  // Restoring step; the dividend shifts out the top as quotient bits enter below.
  assign den_x = {1'b0, in_den};
  assign tmp1  = {in_rem1, in_nq1[NW-1]};
  assign tmp2  = {in_rem2, in_nq2[NW-1]};
  assign ge1   = tmp1 >= den_x;
  assign ge2   = tmp2 >= den_x;
  assign dif1  = tmp1 - den_x;
  assign dif2  = tmp2 - den_x;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_ctl <= '0;
    end else if (adv) begin
      out_ctl <= in_ctl;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_den  <= in_den;
      out_rem1 <= ge1 ? dif1[qnr_pkg::DEN_W-1:0] : tmp1[qnr_pkg::DEN_W-1:0];
      out_rem2 <= ge2 ? dif2[qnr_pkg::DEN_W-1:0] : tmp2[qnr_pkg::DEN_W-1:0];
      out_nq1  <= {in_nq1[NW-2:0], ge1};
      out_nq2  <= {in_nq2[NW-2:0], ge2};
    end
  end

endmodule
`default_nettype wire

[sv/qnr_tail.sv]
// Root selection: threshold tests, root product test and output clamping.
`default_nettype none
module qnr_tail #(
  parameter int FRAC_BITS = 16,
  parameter int NW        = 50
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         adv,
  input  qnr_pkg::ctl_t                in_ctl,
  input  logic [NW-1:0]                in_q1,
  input  logic [NW-1:0]                in_q2,
  input  logic [qnr_pkg::EPS_W-1:0]    eps,
  output logic                         res_valid,
  output logic                         res_hit,
  output logic [qnr_pkg::DIST_W-1:0]   res_distance,
  output logic                         res_saturated
);

  localparam int TW = NW + 1;
  localparam int LW = qnr_pkg::EPS_W + FRAC_BITS;
  localparam int H  = (LW + 1) / 2;
  localparam int HW = LW - H;
  localparam int PW = 2 * LW;
  localparam logic [qnr_pkg::DIST_W-1:0] NEG_ONE =
    qnr_pkg::DIST_W'(0) - (qnr_pkg::DIST_W'(1) << FRAC_BITS);

  logic [LW-1:0] lim;
  assign lim = {eps, {FRAC_BITS{1'b0}}};

  // First stage: signed roots, threshold tests, magnitudes for the product.
  logic signed [TW-1:0] t1_c, t2_c;
  logic                 ge1_c, ge2_c, pass_c, big_c;

  assign t1_c   = in_ctl.neg1 ? -$signed({1'b0, in_q1}) : $signed({1'b0, in_q1});
  assign t2_c   = in_ctl.neg2 ? -$signed({1'b0, in_q2}) : $signed({1'b0, in_q2});
  assign ge1_c  = !(in_ctl.neg1 && in_q1 != '0) && in_q1 >= NW'(eps);
  assign ge2_c  = !(in_ctl.neg2 && in_q2 != '0) && in_q2 >= NW'(eps);
  assign pass_c = in_q1 == '0 || in_q2 == '0 || in_ctl.neg1 != in_ctl.neg2;
  // Either magnitude above the limit already makes the product too large.
  assign big_c  = in_q1 > NW'(lim) || in_q2 > NW'(lim);

  qnr_pkg::ctl_t        s1_ctl;
  logic signed [TW-1:0] s1_t1, s1_t2;
  logic                 s1_ge1, s1_ge2, s1_pass, s1_big;
  logic [LW-1:0]        s1_m1, s1_m2;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_ctl <= '0;
    end else if (adv) begin
      s1_ctl <= in_ctl;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_t1   <= t1_c;
      s1_t2   <= t2_c;
      s1_ge1  <= ge1_c;
      s1_ge2  <= ge2_c;
      s1_pass <= pass_c;
      s1_big  <= big_c;
      s1_m1   <= in_q1[LW-1:0];
      s1_m2   <= in_q2[LW-1:0];
    end
  end

  // Second stage: partial products and the root choice.
  qnr_pkg::ctl_t        s2_ctl;
  logic signed [TW-1:0] s2_t;
  logic                 s2_both, s2_pass, s2_big;
  logic [2*H-1:0]       s2_ll;
  logic [H+HW-1:0]      s2_lh, s2_hl;
  logic [2*HW-1:0]      s2_hh;
  logic                 both_c;
  logic signed [TW-1:0] tsel_c;

  assign both_c = s1_ge1 && s1_ge2;
  assign tsel_c = both_c ? ((s1_t1 < s1_t2) ? s1_t1 : s1_t2) : (s1_ge1 ? s1_t1 : s1_t2);

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_ctl <= '0;
    end else if (adv) begin
      s2_ctl <= s1_ctl;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_t    <= tsel_c;
      s2_both <= both_c;
      s2_pass <= s1_pass;
      s2_big  <= s1_big;
      s2_ll   <= s1_m1[H-1:0] * s1_m2[H-1:0];
      s2_lh   <= s1_m1[H-1:0] * s1_m2[LW-1:H];
      s2_hl   <= s1_m1[LW-1:H] * s1_m2[H-1:0];
      s2_hh   <= s1_m1[LW-1:H] * s1_m2[LW-1:H];
    end
  end

  // Final sum, product test, hit decision and clamping to 32 bits.
  logic [PW-1:0]        prod;
  logic                 prod_ok, hit_c, fits;
  logic [TW-1:32-1]     top_bits;

  assign prod = PW'(s2_ll) + (PW'(s2_lh) << H) + (PW'(s2_hl) << H) + (PW'(s2_hh) << (2 * H));
  assign prod_ok  = s2_pass || (!s2_big && prod <= PW'(lim));
  assign hit_c    = s2_ctl.go && (s2_both || prod_ok);
  assign top_bits = s2_t[TW-1:31];
  assign fits     = (&top_bits) || !(|top_bits);

  assign res_valid     = s2_ctl.valid;
  assign res_hit       = hit_c;
  assign res_saturated = hit_c && !fits;
  assign res_distance  = !hit_c ? NEG_ONE :
                         fits ? s2_t[qnr_pkg::DIST_W-1:0] :
                         (s2_t[TW-1] ? qnr_pkg::DIST_MIN : qnr_pkg::DIST_MAX);

endmodule
`default_nettype wire

[sv/quadratic_nearest_root.sv]
// Top level of the quadratic nearest root block.
//
// Each input beat on s_* carries the coefficients a, b, c of a ray-surface
// quadratic in signed Q.FRAC_BITS; every beat yields exactly one result
// beat on m_*, in order. The result gives hit, the nearest qualifying root
// as distance (-1.0 on no hit) and saturated when the root was clamped.
// The APB port holds the epsilon register at byte address 0.
// The datapath is a fully pipelined row of cells: two multiply and
// discriminant stages, 33 square root cells (one root bit each), one
// numerator stage, FRAC_BITS+34 divider cells (one quotient bit for both
// roots each) and two selection stages, then the output register.
// One beat is taken every cycle as long as the receiver keeps up.
// When m_tready is low with a result waiting, the whole row holds and
// s_tready drops in the same cycle; nothing is lost or repeated.
// Synchronous reset empties the row, drops m_tvalid and sets epsilon
// back to 66.
`default_nettype none
`include "quadratic_nearest_root_defines.svh"
module quadratic_nearest_root #(
  parameter int FRAC_BITS = 16
) (
  input  logic        clk,
  input  logic        rst,
  // Input beat.
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [95:0] s_tdata,   // coef_a [31:0], coef_b [63:32], coef_c [95:64]
  // Result beat.
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // distance [31:0]
  output logic [1:0]  m_tuser,   // hit [0], saturated [1]
  // Register port.
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int NW = qnr_pkg::NUM_W + FRAC_BITS;
  localparam int LW = qnr_pkg::EPS_W + FRAC_BITS;
  localparam logic [qnr_pkg::DIST_W-1:0] NEG_ONE =
    qnr_pkg::DIST_W'(0) - (qnr_pkg::DIST_W'(1) << FRAC_BITS);

  // Register port.
  logic [qnr_pkg::EPS_W-1:0] eps;
  logic                      reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = paddr[2];
  assign prdata  = (reg_idx == qnr_pkg::REG_EPSILON) ? 32'(eps) : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      eps <= qnr_pkg::EPS_RESET;
    end else if (psel && penable && pwrite && pready && reg_idx == qnr_pkg::REG_EPSILON) begin
      eps <= pwdata[qnr_pkg::EPS_W-1:0];
    end
  end

  // The whole row moves when the output register is free or being drained.
  logic out_valid;
  logic adv;

  assign adv      = !out_valid || m_tready;
  assign s_tready = adv;

  // Stage 0: b*b and a*c.
  logic signed [31:0] in_a, in_b, in_c;
  assign in_a = s_tdata[31:0];
  assign in_b = s_tdata[63:32];
  assign in_c = s_tdata[95:64];

  logic               v0;
  logic signed [31:0] a0, b0;
  logic signed [63:0] bb0, ac0;

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
    end else if (adv) begin
      v0 <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      a0  <= in_a;
      b0  <= in_b;
      bb0 <= in_b * in_b;
      ac0 <= in_a * in_c;
    end
  end

  // Stage 1: discriminant D = 4*(bb/4 - ac) + (bb mod 4), exact in 66 bits.
  logic signed [64:0]      qw;
  logic                    v1, qneg1, anz1;
  logic signed [31:0]      a1, b1;
  logic [qnr_pkg::D_W-1:0] d1;

  assign qw = $signed({3'b000, bb0[63:2]}) - 65'(ac0);

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (adv) begin
      v1 <= v0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      a1    <= a0;
      b1    <= b0;
      d1    <= {qw[63:0], bb0[1:0]};
      qneg1 <= qw[64];
      anz1  <= a0 != 32'sd0;
    end
  end

  // Square root row.
  logic [LW-1:0] lim;
  assign lim = {eps, {FRAC_BITS{1'b0}}};

  qnr_pkg::ctl_t               sq_ctl  [0:qnr_pkg::SQRT_CELLS];
  qnr_pkg::ab_t                sq_ab   [0:qnr_pkg::SQRT_CELLS];
  logic [qnr_pkg::SREM_W-1:0]  sq_rem  [0:qnr_pkg::SQRT_CELLS];
  logic [qnr_pkg::ROOT_W-1:0]  sq_root [0:qnr_pkg::SQRT_CELLS];
  logic [qnr_pkg::D_W-1:0]     sq_d    [0:qnr_pkg::SQRT_CELLS];

  // A zero a, a negative discriminant or one below the threshold is no hit.
  assign sq_ctl[0].valid = v1;
  assign sq_ctl[0].go    = anz1 && !qneg1 && d1 >= qnr_pkg::D_W'(lim);
  assign sq_ctl[0].neg1  = 1'b0;
  assign sq_ctl[0].neg2  = 1'b0;
  assign sq_ab[0].a      = a1;
  assign sq_ab[0].b      = b1;
  assign sq_rem[0]       = '0;
  assign sq_root[0]      = '0;
  assign sq_d[0]         = d1;

  for (genvar i = 0; i < qnr_pkg::SQRT_CELLS; i++) begin : g_sqrt
    qnr_sqrt_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .adv      (adv),
      .in_ctl   (sq_ctl[i]),
      .in_ab    (sq_ab[i]),
      .in_rem   (sq_rem[i]),
      .in_root  (sq_root[i]),
      .in_d     (sq_d[i]),
      .out_ctl  (sq_ctl[i+1]),
      .out_ab   (sq_ab[i+1]),
      .out_rem  (sq_rem[i+1]),
      .out_root (sq_root[i+1]),
      .out_d    (sq_d[i+1])
    );
  end

  // Numerator stage: -b + s and -b - s, their magnitudes and quotient signs.
  qnr_pkg::ctl_t          sq_last;
  qnr_pkg::ab_t           ab_last;
  logic signed [34:0]     bx, sx, num1, num2;
  logic [34:0]            abs1, abs2;
  logic [31:0]            abs_a;

  assign sq_last = sq_ctl[qnr_pkg::SQRT_CELLS];
  assign ab_last = sq_ab[qnr_pkg::SQRT_CELLS];
  assign bx      = 35'(ab_last.b);
  assign sx      = $signed(35'(sq_root[qnr_pkg::SQRT_CELLS]));
  assign num1    = sx - bx;
  assign num2    = -bx - sx;
  assign abs1    = num1[34] ? 35'(-num1) : 35'(num1);
  assign abs2    = num2[34] ? 35'(-num2) : 35'(num2);
  assign abs_a   = ab_last.a[31] ? 32'(-ab_last.a) : 32'(ab_last.a);

  qnr_pkg::ctl_t              dv_ctl  [0:NW];
  logic [qnr_pkg::DEN_W-1:0]  dv_den  [0:NW];
  logic [qnr_pkg::DEN_W-1:0]  dv_rem1 [0:NW];
  logic [qnr_pkg::DEN_W-1:0]  dv_rem2 [0:NW];
  logic [NW-1:0]              dv_nq1  [0:NW];
  logic [NW-1:0]              dv_nq2  [0:NW];

  always_ff @(posedge clk) begin
    if (rst) begin
      dv_ctl[0] <= '0;
    end else if (adv) begin
      dv_ctl[0].valid <= sq_last.valid;
      dv_ctl[0].go    <= sq_last.go;
      dv_ctl[0].neg1  <= num1[34] ^ ab_last.a[31];
      dv_ctl[0].neg2  <= num2[34] ^ ab_last.a[31];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dv_den[0]  <= {abs_a, 1'b0};
      dv_rem1[0] <= '0;
      dv_rem2[0] <= '0;
      dv_nq1[0]  <= {abs1[qnr_pkg::NUM_W-1:0], {FRAC_BITS{1'b0}}};
      dv_nq2[0]  <= {abs2[qnr_pkg::NUM_W-1:0], {FRAC_BITS{1'b0}}};
    end
  end

  // Divider row: both roots divided by 2a side by side.
  for (genvar j = 0; j < NW; j++) begin : g_div
    qnr_div_cell #(.NW(NW)) u_cell (
      .clk      (clk),
      .rst      (rst),
      .adv      (adv),
      .in_ctl   (dv_ctl[j]),
      .in_den   (dv_den[j]),
      .in_rem1  (dv_rem1[j]),
      .in_rem2  (dv_rem2[j]),
      .in_nq1   (dv_nq1[j]),
      .in_nq2   (dv_nq2[j]),
      .out_ctl  (dv_ctl[j+1]),
      .out_den  (dv_den[j+1]),
      .out_rem1 (dv_rem1[j+1]),
      .out_rem2 (dv_rem2[j+1]),
      .out_nq1  (dv_nq1[j+1]),
      .out_nq2  (dv_nq2[j+1])
    );
  end

  // Root selection.
  logic                        res_valid, res_hit, res_sat;
  logic [qnr_pkg::DIST_W-1:0]  res_dist;

  qnr_tail #(.FRAC_BITS(FRAC_BITS), .NW(NW)) u_tail (
    .clk           (clk),
    .rst           (rst),
    .adv           (adv),
    .in_ctl        (dv_ctl[NW]),
    .in_q1         (dv_nq1[NW]),
    .in_q2         (dv_nq2[NW]),
    .eps           (eps),
    .res_valid     (res_valid),
    .res_hit       (res_hit),
    .res_distance  (res_dist),
    .res_saturated (res_sat)
  );

  // Output register.
  logic                       out_hit, out_sat;
  logic [qnr_pkg::DIST_W-1:0] out_dist;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_hit  <= res_hit;
      out_sat  <= res_sat;
      out_dist <= res_dist;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = out_dist;
  assign m_tuser  = {out_sat, out_hit};

  // Checks.
  `QNR_ASSERT(a_nohit_value, m_tvalid && !m_tuser[0], m_tdata == NEG_ONE && !m_tuser[1], "no-hit")
  `QNR_ASSERT(a_sat_needs_hit, m_tvalid && m_tuser[1], m_tuser[0], "clamp flagged without a hit")
  `QNR_ASSERT_ALWAYS(a_reset_empty, rst, ##1 !m_tvalid, "result valid right after reset")

endmodule
`default_nettype wire
